[hdl/pip4_pkg.sv]
// ----------------------------------------------------------------------------
// pip4_pkg
// shared types and codes for the four-ray point-in-polygon classifier
// ----------------------------------------------------------------------------
package pip4_pkg;

  localparam int CoordW = 32;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [1:0] {
    HIT_NONE   = 2'd0,
    HIT_CROSS  = 2'd1,
    HIT_EDGE   = 2'd2,
    HIT_VERTEX = 2'd3
  } hit_t;

  typedef enum logic [1:0] {
    VERDICT_OUTSIDE   = 2'd0,
    VERDICT_INSIDE    = 2'd1,
    VERDICT_ON_EDGE   = 2'd2,
    VERDICT_ON_VERTEX = 2'd3
  } verdict_t;

  typedef struct packed {
    hit_t   hit;
    coord_t crossing;
  } ray_res_t;

endpackage

[hdl/pip4_div.sv]
// ----------------------------------------------------------------------------
// pip4_div
// bit-serial floor(m*u/w): restoring divide of m by w, then a shift-add pass
// over the bits of u that folds in the remainder term
// ----------------------------------------------------------------------------
module pip4_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pip4_pkg::CoordW-1:0]    m,
  input  logic [pip4_pkg::CoordW-1:0]    w,
  input  logic [pip4_pkg::CoordW-1:0]    u,
  output logic                           done,
  output logic [pip4_pkg::CoordW-1:0]    val
);
  import pip4_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIVM, S_FRAC} state_t;

  localparam int CntW = $clog2(CoordW);

  state_t            state;
  logic [CntW-1:0]   cnt;
  logic [CoordW-1:0] msh, ush, wr, qa, rem, rr;
  logic [CoordW:0]   acc;

  logic [CoordW:0]   d_rem, f_t1, f_t2;
  logic [CoordW-1:0] f_t1b;
  logic              d_ge, f_c1, f_c2;
  logic [CoordW:0]   acc_next;

  always_comb begin
    d_rem    = {rem, msh[CoordW-1]};
    d_ge     = d_rem >= {1'b0, wr};
    f_t1     = {rem, 1'b0};
    f_c1     = f_t1 >= {1'b0, wr};
    f_t1b    = f_c1 ? CoordW'(f_t1 - {1'b0, wr}) : f_t1[CoordW-1:0];
    f_t2     = {1'b0, f_t1b} + (ush[CoordW-1] ? {1'b0, rr} : '0);
    f_c2     = f_t2 >= {1'b0, wr};
    acc_next = {acc[CoordW-1:0], 1'b0} + (ush[CoordW-1] ? {1'b0, qa} : '0)
             + (CoordW+1)'(f_c1) + (CoordW+1)'(f_c2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            msh   <= m;
            ush   <= u;
            wr    <= w;
            rem   <= '0;
            qa    <= '0;
            cnt   <= '1;
            state <= S_DIVM;
          end
        end
        S_DIVM: begin
          done <= 1'b0;
          qa   <= {qa[CoordW-2:0], d_ge};
          msh  <= {msh[CoordW-2:0], 1'b0};
          if (cnt == '0) begin
            rr    <= d_ge ? CoordW'(d_rem - {1'b0, wr}) : d_rem[CoordW-1:0];
            rem   <= '0;
            acc   <= '0;
            cnt   <= '1;
            state <= S_FRAC;
          end else begin
            rem <= d_ge ? CoordW'(d_rem - {1'b0, wr}) : d_rem[CoordW-1:0];
            cnt <= cnt - 1'b1;
          end
        end
        S_FRAC: begin
          rem  <= f_c2 ? CoordW'(f_t2 - {1'b0, wr}) : f_t2[CoordW-1:0];
          acc  <= acc_next;
          ush  <= {ush[CoordW-2:0], 1'b0};
          cnt  <= cnt - 1'b1;
          done <= cnt == '0;
          if (cnt == '0) begin
            state <= S_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign val = acc[CoordW-1:0];

  a_done_from_frac: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_FRAC)
    else $error("divider done outside fraction pass");
  a_rem_below_w: assert property (@(posedge clk) disable iff (rst)
    (state == S_FRAC) |-> rem < wr)
    else $error("divider remainder not below divisor");
  a_rr_below_w: assert property (@(posedge clk) disable iff (rst)
    (state == S_FRAC) |-> rr < wr)
    else $error("divider fraction numerator not below divisor");

endmodule

[hdl/pip4_ray.sv]
// ----------------------------------------------------------------------------
// pip4_ray
// tests one edge against a ray along the b axis through (pa, pb) and returns
// the hit kind and the crossing coordinate
// ----------------------------------------------------------------------------
module pip4_ray (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pip4_pkg::coord_t   a0,
  input  pip4_pkg::coord_t   b0,
  input  pip4_pkg::coord_t   a1,
  input  pip4_pkg::coord_t   b1,
  input  pip4_pkg::coord_t   pa,
  input  pip4_pkg::coord_t   pb,
  output logic               done,
  output pip4_pkg::ray_res_t res
);
  import pip4_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN} state_t;

  state_t state;
  coord_t b0r, pbr;
  logic   dneg;

  logic                     swap, vert, par, between, outside;
  coord_t                   sa0, sa1, sb0, sb1, lo, hi;
  logic signed [CoordW:0]   dd;
  logic [CoordW-1:0]        m, w, u, val;
  logic                     div_done;
  logic signed [CoordW:0]   cross_w;
  coord_t                   crossing;

  always_comb begin
    vert     = (pa == a0 && pb == b0) || (pa == a1 && pb == b1);
    swap     = a1 < a0;
    sa0      = swap ? a1 : a0;
    sa1      = swap ? a0 : a1;
    sb0      = swap ? b1 : b0;
    sb1      = swap ? b0 : b1;
    lo       = (sb0 < sb1) ? sb0 : sb1;
    hi       = (sb0 < sb1) ? sb1 : sb0;
    par      = sa0 == sa1;
    between  = (pa == sa0) && (pb > lo) && (pb < hi);
    outside  = (pa < sa0) || (pa > sa1);
    w        = CoordW'({sa1[CoordW-1], sa1} - {sa0[CoordW-1], sa0});
    u        = CoordW'({pa[CoordW-1], pa} - {sa0[CoordW-1], sa0});
    dd       = {sb1[CoordW-1], sb1} - {sb0[CoordW-1], sb0};
    m        = dd[CoordW] ? CoordW'(-dd) : dd[CoordW-1:0];
    cross_w  = dneg ? ({b0r[CoordW-1], b0r} - {1'b0, val})
                    : ({b0r[CoordW-1], b0r} + {1'b0, val});
    crossing = cross_w[CoordW-1:0];
  end

  pip4_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(start && state == S_IDLE && !vert && !par && !outside),
    .m    (m),
    .w    (w),
    .u    (u),
    .done (div_done),
    .val  (val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= start && (vert || par || outside);
          if (start) begin
            b0r  <= sb0;
            pbr  <= pb;
            dneg <= dd[CoordW];
            res.crossing <= '0;
            priority if (vert) begin
              res.hit <= HIT_VERTEX;
            end else if (par) begin
              res.hit <= between ? HIT_EDGE : HIT_NONE;
            end else if (outside) begin
              res.hit <= HIT_NONE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          done <= 1'b0;
          if (div_done) state <= S_FIN;
        end
        S_FIN: begin
          res.crossing <= crossing;
          res.hit      <= (crossing == pbr) ? HIT_EDGE : HIT_CROSS;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !start)
    else $error("ray started while busy");
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider result with no ray waiting");
  a_cross_hit: assert property (@(posedge clk) disable iff (rst)
    (done && res.hit == HIT_CROSS) |-> res.crossing != pbr)
    else $error("crossing reported at the point itself");

endmodule

[hdl/point_in_polygon_four_ray.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_four_ray
// classifies a query point against a streamed counter-clockwise polygon by
// nearest crossings above, right, below and left of the point
//
//   channel  signals                                           dir
//   request  in_valid in_ready vertex_x vertex_y point_x       in
//            point_y first last
//   result   out_valid out_ready verdict                       out
//
// a request with no edge to test goes straight to its final state; an edge casts
// a vertical ray and then a horizontal one, and the bit-serial divider runs when
// the point lies within the edge's span (32 steps of m/w, then 32 steps over u);
// an edge or vertex hit on the vertical ray skips the horizontal one
// in_ready is high only while idle; one request is worked on at a time
// a last request holds in its final cycle while an earlier verdict is not taken;
// a waiting verdict does not block requests that produce none
// rst is synchronous and clears all query state
// ----------------------------------------------------------------------------
module point_in_polygon_four_ray (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pip4_pkg::coord_t     vertex_x,
  input  pip4_pkg::coord_t     vertex_y,
  input  pip4_pkg::coord_t     point_x,
  input  pip4_pkg::coord_t     point_y,
  input  logic                 first,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           verdict
);
  import pip4_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RAY1, S_WAIT1, S_RAY2, S_WAIT2, S_FIN} state_t;

  state_t   state;
  coord_t   query_x, query_y, previous_x, previous_y, cur_x, cur_y;
  logic     have_previous, early_found, last_r;
  hit_t     early_verdict;
  coord_t   nearest_crossing [4];
  logic [3:0] crossing_valid, crossing_faces_out;

  logic     second, ray_start, ray_done, all_ok;
  coord_t   ra0, rb0, ra1, rb1, rpa, rpb;
  ray_res_t ray_res;

  assign in_ready  = state == S_IDLE;
  assign second    = state == S_RAY2 || state == S_WAIT2;
  assign ray_start = state == S_RAY1 || state == S_RAY2;
  assign all_ok    = &(crossing_valid & crossing_faces_out);

  always_comb begin
    ra0 = second ? previous_y : previous_x;
    rb0 = second ? previous_x : previous_y;
    ra1 = second ? cur_y : cur_x;
    rb1 = second ? cur_x : cur_y;
    rpa = second ? query_y : query_x;
    rpb = second ? query_x : query_y;
  end

  pip4_ray u_ray (
    .clk  (clk),
    .rst  (rst),
    .start(ray_start),
    .a0   (ra0),
    .b0   (rb0),
    .a1   (ra1),
    .b1   (rb1),
    .pa   (rpa),
    .pb   (rpb),
    .done (ray_done),
    .res  (ray_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      query_x            <= '0;
      query_y            <= '0;
      previous_x         <= '0;
      previous_y         <= '0;
      have_previous      <= 1'b0;
      early_found        <= 1'b0;
      early_verdict      <= HIT_NONE;
      crossing_valid     <= '0;
      crossing_faces_out <= '0;
      for (int i = 0; i < 4; i++) nearest_crossing[i] <= '0;
      out_valid          <= 1'b0;
      verdict            <= VERDICT_OUTSIDE;
      last_r             <= 1'b0;
    end else begin
      if (out_valid && out_ready && !(state == S_FIN && last_r)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_x  <= vertex_x;
            cur_y  <= vertex_y;
            last_r <= last;
            if (first) begin
              query_x            <= point_x;
              query_y            <= point_y;
              have_previous      <= 1'b0;
              early_found        <= 1'b0;
              early_verdict      <= HIT_NONE;
              crossing_valid     <= '0;
              crossing_faces_out <= '0;
              for (int i = 0; i < 4; i++) nearest_crossing[i] <= '0;
            end
            state <= (!first && have_previous && !early_found) ? S_RAY1 : S_FIN;
          end
        end
        S_RAY1: state <= S_WAIT1;
        S_WAIT1: begin
          if (ray_done) begin
            priority if (ray_res.hit == HIT_EDGE || ray_res.hit == HIT_VERTEX) begin
              early_found   <= 1'b1;
              early_verdict <= ray_res.hit;
              state         <= S_FIN;
            end else begin
              if (ray_res.hit == HIT_CROSS) begin
                if (ray_res.crossing > query_y) begin
                  if (!crossing_valid[0] || ray_res.crossing < nearest_crossing[0]) begin
                    crossing_valid[0]     <= 1'b1;
                    nearest_crossing[0]   <= ray_res.crossing;
                    crossing_faces_out[0] <= cur_x < previous_x;
                  end
                end else begin
                  if (!crossing_valid[2] || ray_res.crossing > nearest_crossing[2]) begin
                    crossing_valid[2]     <= 1'b1;
                    nearest_crossing[2]   <= ray_res.crossing;
                    crossing_faces_out[2] <= cur_x > previous_x;
                  end
                end
              end
              state <= S_RAY2;
            end
          end
        end
        S_RAY2: state <= S_WAIT2;
        S_WAIT2: begin
          if (ray_done) begin
            if (ray_res.hit == HIT_EDGE || ray_res.hit == HIT_VERTEX) begin
              early_found   <= 1'b1;
              early_verdict <= ray_res.hit;
            end else if (ray_res.hit == HIT_CROSS) begin
              if (ray_res.crossing > query_x) begin
                if (!crossing_valid[1] || ray_res.crossing < nearest_crossing[1]) begin
                  crossing_valid[1]     <= 1'b1;
                  nearest_crossing[1]   <= ray_res.crossing;
                  crossing_faces_out[1] <= cur_y > previous_y;
                end
              end else begin
                if (!crossing_valid[3] || ray_res.crossing > nearest_crossing[3]) begin
                  crossing_valid[3]     <= 1'b1;
                  nearest_crossing[3]   <= ray_res.crossing;
                  crossing_faces_out[3] <= cur_y < previous_y;
                end
              end
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!last_r || !out_valid || out_ready) begin
            previous_x    <= cur_x;
            previous_y    <= cur_y;
            have_previous <= 1'b1;
            state         <= S_IDLE;
            if (last_r) begin
              out_valid <= 1'b1;
              verdict   <= early_found ? 2'(early_verdict)
                                       : (all_ok ? 2'(VERDICT_INSIDE) : 2'(VERDICT_OUTSIDE));
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_early_code: assert property (@(posedge clk) disable iff (rst)
    early_found |-> (early_verdict == HIT_EDGE || early_verdict == HIT_VERTEX))
    else $error("early verdict without an edge or vertex code");
  a_no_prev_no_cross: assert property (@(posedge clk) disable iff (rst)
    !have_previous |-> crossing_valid == '0)
    else $error("crossing kept with no previous vertex");
  a_ray_done_waiting: assert property (@(posedge clk) disable iff (rst)
    ray_done |-> (state == S_WAIT1 || state == S_WAIT2))
    else $error("ray result with no edge in progress");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(verdict))
    else $error("verdict changed while waiting");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// streams polygons into the four-ray point-in-polygon classifier with random
// gaps and stalls, predicts each verdict in parallel and compares it in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import pip4_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t vertex_x = '0, vertex_y = '0, point_x = '0, point_y = '0;
  logic first = 1'b0, last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] verdict;

  point_in_polygon_four_ray u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .point_x(point_x),
    .point_y(point_y), .first(first), .last(last), .out_valid(out_valid),
    .out_ready(out_ready), .verdict(verdict)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  longint qx, qy, px_prev, py_prev;
  bit have_prev, hit_found;
  verdict_t hit_verdict;
  longint near_c[4];
  bit near_ok[4], near_out[4];

  verdict_t verdict_q[$];
  int errors = 0;
  int idle_pct = 9;
  bit hold_off = 1'b0;
  int quiet = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void clear_query();
    have_prev = 0;
    hit_found = 0;
    hit_verdict = VERDICT_OUTSIDE;
    for (int i = 0; i < 4; i++) begin
      near_c[i] = 0;
      near_ok[i] = 0;
      near_out[i] = 0;
    end
  endfunction

  // ray along the b axis through (pa,pb)
  function automatic hit_t cast_ray(input longint a0, b0, a1, b1, pa, pb,
                                    output longint c);
    longint t, w, u, d, m;
    longint unsigned fr;
    c = 0;
    if ((pa == a0 && pb == b0) || (pa == a1 && pb == b1)) return HIT_VERTEX;
    if (a1 < a0) begin
      t = a0; a0 = a1; a1 = t;
      t = b0; b0 = b1; b1 = t;
    end
    if (a0 == a1) begin
      if (pa != a0) return HIT_NONE;
      if ((pb > b0 && pb < b1) || (pb > b1 && pb < b0)) return HIT_EDGE;
      return HIT_NONE;
    end
    if (pa < a0 || pa > a1) return HIT_NONE;
    w = a1 - a0;
    u = pa - a0;
    d = b1 - b0;
    m = d < 0 ? -d : d;
    // remainder term in unsigned 64 bits: (m % w) * u stays below 2^64
    fr = ($unsigned(m % w) * $unsigned(u)) / $unsigned(w);
    t = (m / w) * u + longint'(fr);
    c = d < 0 ? b0 - t : b0 + t;
    return (pb == c) ? HIT_EDGE : HIT_CROSS;
  endfunction

  function automatic void keep_crossing(int s, longint c, bit closer, bit faces);
    if (!near_ok[s] || closer) begin
      near_ok[s] = 1;
      near_c[s] = c;
      near_out[s] = faces;
    end
  endfunction

  function automatic void test_edge(longint ax, ay, bx, by);
    longint c;
    hit_t h;
    h = cast_ray(ax, ay, bx, by, qx, qy, c);
    if (h == HIT_EDGE || h == HIT_VERTEX) begin
      hit_found = 1; hit_verdict = verdict_t'(h); return;
    end
    if (h == HIT_CROSS) begin
      if (c > qy) keep_crossing(0, c, c < near_c[0], bx < ax);
      else keep_crossing(2, c, c > near_c[2], bx > ax);
    end
    h = cast_ray(ay, ax, by, bx, qy, qx, c);
    if (h == HIT_EDGE || h == HIT_VERTEX) begin
      hit_found = 1; hit_verdict = verdict_t'(h); return;
    end
    if (h == HIT_CROSS) begin
      if (c > qx) keep_crossing(1, c, c < near_c[1], by > ay);
      else keep_crossing(3, c, c > near_c[3], by < ay);
    end
  endfunction

  function automatic void predict_vertex(coord_t vx, vy, ptx, pty, bit f, l);
    bit all_ok = 1;
    if (f) begin
      clear_query();
      qx = ptx;
      qy = pty;
    end
    if (have_prev && !hit_found) test_edge(px_prev, py_prev, vx, vy);
    px_prev = vx;
    py_prev = vy;
    have_prev = 1;
    if (!l) return;
    if (hit_found) begin
      verdict_q.push_back(hit_verdict);
      return;
    end
    for (int i = 0; i < 4; i++) if (!near_ok[i] || !near_out[i]) all_ok = 0;
    verdict_q.push_back(all_ok ? VERDICT_INSIDE : VERDICT_OUTSIDE);
  endfunction

  task automatic send_vertex(input coord_t vx, vy, ptx, pty, input bit f, l);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    vertex_x <= vx; vertex_y <= vy; point_x <= ptx; point_y <= pty;
    first <= f; last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_vertex(vx, vy, ptx, pty, f, l);
  endtask

  // result side
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) report_mismatch("verdict with none expected");
        else begin
          verdict_t e;
          e = verdict_q.pop_front();
          if (verdict !== e)
            report_mismatch($sformatf("verdict %0d expected %0d", verdict, e));
        end
      end
      out_ready <= !hold_off && !(idle_pct > 0 && $urandom_range(99) < idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic coord_t rand_coord(int span);
    return coord_t'($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic coord_t wild_coord();
    case ($urandom_range(3))
      0: return coord_t'(32'h8000_0000);
      1: return coord_t'(32'h7fff_ffff);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // square of half-side r centred on (cx, cy), wound counter-clockwise or clockwise
  task automatic send_box(coord_t cx, cy, ptx, pty, coord_t r, bit ccw);
    coord_t xs[5], ys[5];
    xs = '{cx + r, cx - r, cx - r, cx + r, cx + r};
    ys = '{cy + r, cy + r, cy - r, cy - r, cy + r};
    for (int i = 0; i < 5; i++) begin
      int k = ccw ? i : 4 - i;
      send_vertex(xs[k], ys[k], ptx, pty, i == 0, i == 4);
    end
  endtask

  task automatic test_directed();
    send_box(0, 0, 0, 0, 32'h0001_0000, 1);          // inside
    send_box(0, 0, 0, 0, 32'h0001_0000, 0);          // clockwise, wrong facing
    send_box(0, 0, 32'h0001_0000, 0, 32'h0001_0000, 1); // on edge
    send_box(0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1); // vertex
    send_box(0, 0, 32'h0005_0000, 0, 32'h0001_0000, 1); // outside
    send_vertex(5, 5, 7, 7, 1, 1);                    // lone vertex
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1, 0);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 1);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 1); // continues after last
  endtask

  task automatic test_random_polygons();
    int n = 0;
    while (n < 340) begin
      int kind = $urandom_range(9);
      if (kind < 6) begin
        int span = ($urandom_range(3) == 0) ? 8 : 32'h0004_0000;
        send_box(rand_coord(span), rand_coord(span), rand_coord(span),
                 rand_coord(span), coord_t'($urandom_range(span) + 1),
                 $urandom_range(4) != 0);
        n += 5;
      end else begin
        int len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if (kind == 9) send_vertex(wild_coord(), wild_coord(), wild_coord(),
                                     wild_coord(), i == 0, i == len - 1);
          else send_vertex(rand_coord(6), rand_coord(6), rand_coord(6),
                           rand_coord(6), i == 0 && $urandom_range(5) != 0,
                           i == len - 1);
          n++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++)
        send_box(0, 0, rand_coord(3), rand_coord(3), 2, 1);
    join
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    for (int i = 0; i < 8; i++)
      send_box(rand_coord(9), rand_coord(9), rand_coord(9), rand_coord(9),
               coord_t'($urandom_range(9) + 1), 1);
    idle_pct = 9;
  endtask

  initial begin
    clear_query();
    qx = 0; qy = 0; px_prev = 0; py_prev = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_no_idle();
    test_random_polygons();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
